// ===== design/max_pool_2d_stream_unit_macros.svh =====
// assertion helpers for the max pooling block
// clk and arst_n are taken from the module that uses them
`ifndef MAX_POOL_2D_STREAM_UNIT_MACROS_SVH
`define MAX_POOL_2D_STREAM_UNIT_MACROS_SVH

// same-cycle implication
`define MP2D_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MP2D_LEADS_TO(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/mp2d_pkg.sv =====
`default_nettype none
package mp2d_pkg;

	localparam int SAMPLE_BITS  = 16;
	localparam int MAX_WIDTH    = 256;
	localparam int MAX_CHANNELS = 64;

	localparam int CHAN_BITS = $clog2(MAX_CHANNELS);
	localparam int OCOL_BITS = $clog2(MAX_WIDTH);
	localparam int ADDR_BITS = OCOL_BITS + CHAN_BITS;
	localparam int MEM_DEPTH = MAX_WIDTH * MAX_CHANNELS;

	// register widths
	localparam int PH_BITS   = 5;
	localparam int PW_BITS   = 5;
	localparam int H_BITS    = 11;
	localparam int W_BITS    = 9;
	localparam int C_BITS    = 7;
	localparam int ROW_BITS  = 10;
	localparam int WIN_BITS  = 4;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 11;

	localparam logic [CFG_INDEX_BITS-1:0] REG_POOL_HEIGHT   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_POOL_WIDTH    = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IN_HEIGHT     = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IN_WIDTH      = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 3'd4;

	localparam int POOL_LIMIT   = 16;
	localparam int HEIGHT_LIMIT = 1024;

	localparam logic [PH_BITS-1:0] PH_RESET = 5'd2;
	localparam logic [PW_BITS-1:0] PW_RESET = 5'd2;
	localparam logic [H_BITS-1:0]  H_RESET  = 11'd1;
	localparam logic [W_BITS-1:0]  W_RESET  = 9'd1;
	localparam logic [C_BITS-1:0]  C_RESET  = 7'd1;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic [ADDR_BITS-1:0]   addr;
		logic                   first;
		logic                   emit;
		logic                   last;
	} q_entry_t;

	typedef struct packed {
		logic head_valid;
		logic full;
	} q_status_t;

	// zero acts as one, oversized values saturate
	function automatic logic [CFG_DATA_BITS-1:0] clamp_size(
		input logic [CFG_DATA_BITS-1:0] v,
		input logic [CFG_DATA_BITS-1:0] hi
	);
		logic [CFG_DATA_BITS-1:0] r;
		if (v == '0) begin
			r = CFG_DATA_BITS'(1);
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/mp2d_front.sv =====
`default_nettype none
module mp2d_front (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_write,
	input  wire logic [mp2d_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [mp2d_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  wire logic [mp2d_pkg::SAMPLE_BITS-1:0]      sample,
	input  wire logic                                  sample_valid,
	output logic                                       sample_ready,
	input  wire mp2d_pkg::q_status_t                   q_status,
	output logic                                       push,
	output mp2d_pkg::q_entry_t                         push_entry
);

	logic [mp2d_pkg::PH_BITS-1:0]   ph_q;
	logic [mp2d_pkg::PW_BITS-1:0]   pw_q;
	logic [mp2d_pkg::H_BITS-1:0]    h_q;
	logic [mp2d_pkg::W_BITS-1:0]    w_q;
	logic [mp2d_pkg::C_BITS-1:0]    c_q;

	logic [mp2d_pkg::CHAN_BITS-1:0] chan_q;
	logic [mp2d_pkg::OCOL_BITS-1:0] col_q;
	logic [mp2d_pkg::OCOL_BITS-1:0] col_base_q;
	logic [mp2d_pkg::OCOL_BITS-1:0] ocol_q;
	logic [mp2d_pkg::WIN_BITS-1:0]  win_col_q;
	logic [mp2d_pkg::ROW_BITS-1:0]  row_q;
	logic [mp2d_pkg::ROW_BITS-1:0]  row_base_q;
	logic [mp2d_pkg::WIN_BITS-1:0]  win_row_q;

	logic accept;
	logic row_fit, row_tail, col_fit, col_tail;
	logic win_row_end, win_col_end, chan_end, col_end, row_end;
	logic fit, first, emit, last;

	assign sample_ready = !q_status.full;
	assign accept       = sample_valid && sample_ready;

	// window block fits below / is the last block that fits
	assign row_fit  = (12'(row_base_q) + 12'(ph_q)) <= 12'(h_q);
	assign row_tail = (12'(row_base_q) + 12'({ph_q, 1'b0})) > 12'(h_q);
	assign col_fit  = (10'(col_base_q) + 10'(pw_q)) <= 10'(w_q);
	assign col_tail = (10'(col_base_q) + 10'({pw_q, 1'b0})) > 10'(w_q);

	assign win_row_end = (5'(win_row_q) + 5'd1) == ph_q;
	assign win_col_end = (5'(win_col_q) + 5'd1) == pw_q;
	assign chan_end    = (7'(chan_q) + 7'd1) == c_q;
	assign col_end     = (9'(col_q) + 9'd1) >= w_q;
	assign row_end     = (11'(row_q) + 11'd1) >= h_q;

	assign fit   = row_fit && col_fit;
	assign first = (win_row_q == '0) && (win_col_q == '0);
	assign emit  = fit && win_row_end && win_col_end;
	assign last  = emit && row_tail && col_tail && chan_end;

	assign push = accept && fit;

	always_comb begin
		push_entry.sample = sample;
		push_entry.addr   = {ocol_q, chan_q};
		push_entry.first  = first;
		push_entry.emit   = emit;
		push_entry.last   = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= mp2d_pkg::PH_RESET;
			pw_q <= mp2d_pkg::PW_RESET;
			h_q  <= mp2d_pkg::H_RESET;
			w_q  <= mp2d_pkg::W_RESET;
			c_q  <= mp2d_pkg::C_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				mp2d_pkg::REG_POOL_HEIGHT: begin
					ph_q <= mp2d_pkg::PH_BITS'(mp2d_pkg::clamp_size(
						11'(cfg_data[4:0]), 11'(mp2d_pkg::POOL_LIMIT)));
				end
				mp2d_pkg::REG_POOL_WIDTH: begin
					pw_q <= mp2d_pkg::PW_BITS'(mp2d_pkg::clamp_size(
						11'(cfg_data[4:0]), 11'(mp2d_pkg::POOL_LIMIT)));
				end
				mp2d_pkg::REG_IN_HEIGHT: begin
					h_q <= mp2d_pkg::clamp_size(cfg_data, 11'(mp2d_pkg::HEIGHT_LIMIT));
				end
				mp2d_pkg::REG_IN_WIDTH: begin
					w_q <= mp2d_pkg::W_BITS'(mp2d_pkg::clamp_size(
						11'(cfg_data[8:0]), 11'(mp2d_pkg::MAX_WIDTH)));
				end
				mp2d_pkg::REG_CHANNEL_COUNT: begin
					c_q <= mp2d_pkg::C_BITS'(mp2d_pkg::clamp_size(
						11'(cfg_data[6:0]), 11'(mp2d_pkg::MAX_CHANNELS)));
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q     <= '0;
			col_q      <= '0;
			col_base_q <= '0;
			ocol_q     <= '0;
			win_col_q  <= '0;
			row_q      <= '0;
			row_base_q <= '0;
			win_row_q  <= '0;
		end else if (cfg_write) begin
			chan_q     <= '0;
			col_q      <= '0;
			col_base_q <= '0;
			ocol_q     <= '0;
			win_col_q  <= '0;
			row_q      <= '0;
			row_base_q <= '0;
			win_row_q  <= '0;
		end else if (accept) begin
			if (!chan_end) begin
				chan_q <= chan_q + 1'b1;
			end else begin
				chan_q <= '0;
				if (col_end) begin
					col_q      <= '0;
					col_base_q <= '0;
					ocol_q     <= '0;
					win_col_q  <= '0;
					if (row_end) begin
						row_q      <= '0;
						row_base_q <= '0;
						win_row_q  <= '0;
					end else begin
						row_q <= row_q + 1'b1;
						if (win_row_end) begin
							win_row_q  <= '0;
							row_base_q <= row_q + 1'b1;
						end else begin
							win_row_q <= win_row_q + 1'b1;
						end
					end
				end else begin
					col_q <= col_q + 1'b1;
					if (win_col_end) begin
						win_col_q  <= '0;
						col_base_q <= col_q + 1'b1;
						ocol_q     <= ocol_q + 1'b1;
					end else begin
						win_col_q <= win_col_q + 1'b1;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/mp2d_queue.sv =====
`default_nettype none
module mp2d_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire mp2d_pkg::q_entry_t   push_entry,
	input  wire logic                 pop,
	output mp2d_pkg::q_entry_t        head,
	output mp2d_pkg::q_status_t       status
);

	mp2d_pkg::q_entry_t entry_q [mp2d_pkg::QUEUE_DEPTH];

	logic [mp2d_pkg::QPTR_BITS-1:0] wr_ptr_q;
	logic [mp2d_pkg::QPTR_BITS-1:0] rd_ptr_q;
	logic [mp2d_pkg::QCNT_BITS-1:0] count_q;

	assign head              = entry_q[rd_ptr_q];
	assign status.head_valid = count_q != '0;
	assign status.full       = count_q == mp2d_pkg::QCNT_BITS'(mp2d_pkg::QUEUE_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/mp2d_back.sv =====
`default_nettype none
`include "max_pool_2d_stream_unit_macros.svh"
module mp2d_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire mp2d_pkg::q_entry_t               head,
	input  wire mp2d_pkg::q_status_t              q_status,
	output logic                                  pop,
	output logic [mp2d_pkg::SAMPLE_BITS-1:0]      pooled,
	output logic                                  tensor_done,
	output logic                                  pooled_valid,
	input  wire logic                             pooled_ready
);

	logic [mp2d_pkg::SAMPLE_BITS-1:0] mem [mp2d_pkg::MEM_DEPTH];

	mp2d_pkg::q_entry_t               item_s1;
	logic                             valid_s1;
	logic [mp2d_pkg::SAMPLE_BITS-1:0] rd_s1;
	logic [mp2d_pkg::SAMPLE_BITS-1:0] fwd_s1;
	logic                             fwd_hit_s1;

	logic                             out_valid_q;
	logic [mp2d_pkg::SAMPLE_BITS-1:0] pooled_q;
	logic                             done_q;

	logic                             adv;
	logic                             wr_en;
	logic signed [mp2d_pkg::SAMPLE_BITS-1:0] prior;
	logic signed [mp2d_pkg::SAMPLE_BITS-1:0] smp;
	logic [mp2d_pkg::SAMPLE_BITS-1:0] new_max;

	// stage stalls only when its result cannot enter a full output register
	assign adv   = !valid_s1 || !item_s1.emit || !out_valid_q || pooled_ready;
	assign wr_en = valid_s1 && adv;
	assign pop   = q_status.head_valid && adv;

	assign prior = fwd_hit_s1 ? fwd_s1 : rd_s1;
	assign smp   = item_s1.sample;

	always_comb begin
		if (item_s1.first || (smp > prior)) begin
			new_max = item_s1.sample;
		end else begin
			new_max = prior;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[item_s1.addr] <= new_max;
		end
		if (pop) begin
			rd_s1 <= mem[head.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= head;
			fwd_s1  <= new_max;
		end
		if (wr_en && item_s1.emit) begin
			pooled_q <= new_max;
			done_q   <= item_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_hit_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				valid_s1 <= pop;
				// memory read misses a write landing on the same edge
				fwd_hit_s1 <= pop && wr_en && (item_s1.addr == head.addr);
			end
			if (wr_en && item_s1.emit) begin
				out_valid_q <= 1'b1;
			end else if (pooled_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign pooled       = pooled_q;
	assign tensor_done  = done_q;
	assign pooled_valid = out_valid_q;

	`MP2D_IMPLIES(a_fwd_needs_item, fwd_hit_s1, valid_s1, "bypass set with empty stage")
	`MP2D_LEADS_TO(a_emit_reaches_out, wr_en && item_s1.emit, out_valid_q, "result lost")
	`MP2D_IMPLIES(a_stall_only_on_full_out, valid_s1 && !adv,
		item_s1.emit && out_valid_q && !pooled_ready, "stage stalled without cause")

endmodule
`default_nettype wire

// ===== design/max_pool_2d_stream_unit.sv =====
// channel   | signals                                  | flow
// ----------+------------------------------------------+-------------------------
// sample    | sample, sample_valid, sample_ready       | one tensor word per beat
// pooled    | pooled, tensor_done, pooled_valid/ready  | one window maximum
// config    | cfg_write, cfg_index, cfg_data           | write only, no wait
//
// sustained rate is one sample word per cycle while the queue is not full;
// each word inside a whole window is one memory read and one compare-and-write
// of the running maximum in the back stage; pooled words come from the output
// register, behind the queue and the stage-1 register; sample_ready drops only
// when the four-entry queue is full, i.e. when the pooled side has stalled the
// back stage; reset is asynchronous; the running-maximum memory is not cleared,
// since every window writes its entry on its first sample
`default_nettype none
module max_pool_2d_stream_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write,
	input  wire logic [mp2d_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [mp2d_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic [mp2d_pkg::SAMPLE_BITS-1:0]    sample,
	input  wire logic                                sample_valid,
	output logic                                     sample_ready,
	output logic [mp2d_pkg::SAMPLE_BITS-1:0]         pooled,
	output logic                                     tensor_done,
	output logic                                     pooled_valid,
	input  wire logic                                pooled_ready
);

	// front: position tracking and window classification
	logic                  push;
	mp2d_pkg::q_entry_t    push_entry;
	// queue: decouples front from the memory pipeline
	mp2d_pkg::q_entry_t    head;
	mp2d_pkg::q_status_t   q_status;
	logic                  pop;

	mp2d_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample       (sample),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.q_status     (q_status),
		.push         (push),
		.push_entry   (push_entry)
	);

	// words outside any whole window never enter the queue
	mp2d_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	// back: running-maximum memory, bypass and output register
	mp2d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.pooled       (pooled),
		.tensor_done  (tensor_done),
		.pooled_valid (pooled_valid),
		.pooled_ready (pooled_ready)
	);

endmodule
`default_nettype wire

// ===== test/tb_max_pool_2d_stream_unit.sv =====
`timescale 1ns / 1ps

module tb_max_pool_2d_stream_unit;
	import mp2d_pkg::*;

	// one pooled word as the block should hand it out
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] pooled;
		logic                   done;
	} pooled_word_t;

	localparam int WATCHDOG_LIMIT = 1000;  // longest quiet stretch is the receiver's long hold-off
	localparam int SETTLE_CYCLES  = 12;    // queue of four plus the two-stage back end
	localparam int HOLD_CYCLES    = 64;
	localparam int RANDOM_WORDS   = 520;
	localparam int INDEX_TOP      = 2 ** CFG_INDEX_BITS - 1;
	localparam int REG_FIRST_SPARE = int'(REG_CHANNEL_COUNT) + 1;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_write = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic [SAMPLE_BITS-1:0]    sample = '0;
	logic                      sample_valid = 1'b0;
	logic                      sample_ready;
	logic [SAMPLE_BITS-1:0]    pooled;
	logic                      tensor_done;
	logic                      pooled_valid;
	logic                      pooled_ready = 1'b0;

	max_pool_2d_stream_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample       (sample),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.pooled       (pooled),
		.tensor_done  (tensor_done),
		.pooled_valid (pooled_valid),
		.pooled_ready (pooled_ready)
	);

	always #4 clk = ~clk;

	// shadow copy of the block: registers, window position, running maxima
	logic [PH_BITS-1:0]            pool_h_reg = PH_RESET;
	logic [PW_BITS-1:0]            pool_w_reg = PW_RESET;
	logic [H_BITS-1:0]             rows_reg   = H_RESET;
	logic [W_BITS-1:0]             cols_reg   = W_RESET;
	logic [C_BITS-1:0]             chans_reg  = C_RESET;
	logic signed [SAMPLE_BITS-1:0] running_max [MEM_DEPTH];
	int unsigned                   row_at, col_at, chan_at, win_row_at, win_col_at;

	pooled_word_t expected_pooled[$];

	int unsigned error_count   = 0;
	int unsigned quiet_cycles  = 0;
	int unsigned results_taken = 0;

	// idling controls shared by the sender, the receiver and the tests
	bit          src_idle  = 1'b1;
	bit          sink_idle = 1'b1;
	int unsigned hold_len  = 0;
	int unsigned hold_id   = 0;

	// zero acts as one, anything above the limit saturates
	function automatic int unsigned clipped(input int unsigned v, input int unsigned hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic void restart_tensor();
		row_at = 0;
		col_at = 0;
		chan_at = 0;
		win_row_at = 0;
		win_col_at = 0;
	endfunction

	function automatic void shadow_write(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		case (idx)
			REG_POOL_HEIGHT:   pool_h_reg = data[PH_BITS-1:0];
			REG_POOL_WIDTH:    pool_w_reg = data[PW_BITS-1:0];
			REG_IN_HEIGHT:     rows_reg = data[H_BITS-1:0];
			REG_IN_WIDTH:      cols_reg = data[W_BITS-1:0];
			REG_CHANNEL_COUNT: chans_reg = data[C_BITS-1:0];
			default: ;
		endcase
		// any write, known index or not, starts a fresh tensor
		restart_tensor();
	endfunction

	// running-maximum update for one accepted sample word, queues the window result
	function automatic void pool_predict(input logic [SAMPLE_BITS-1:0] word);
		int unsigned                   ph, pw, h, w, c, full_rows, full_cols, slot;
		logic signed [SAMPLE_BITS-1:0] v;
		pooled_word_t                  res;
		ph = clipped(pool_h_reg, POOL_LIMIT);
		pw = clipped(pool_w_reg, POOL_LIMIT);
		h = clipped(rows_reg, HEIGHT_LIMIT);
		w = clipped(cols_reg, MAX_WIDTH);
		c = clipped(chans_reg, MAX_CHANNELS);
		full_rows = (h / ph) * ph;
		full_cols = (w / pw) * pw;
		v = word;
		// trailing rows and columns are swallowed without touching the maxima
		if (row_at < full_rows && col_at < full_cols) begin
			slot = (col_at / pw) * MAX_CHANNELS + chan_at;
			if ((win_row_at == 0 && win_col_at == 0) || v > running_max[slot])
				running_max[slot] = v;
			if (win_row_at == ph - 1 && win_col_at == pw - 1) begin
				res.pooled = running_max[slot];
				res.done = (row_at == full_rows - 1) && (col_at == full_cols - 1) &&
					(chan_at == c - 1);
				expected_pooled.push_back(res);
			end
		end
		// raster walk: channel fastest, then column, then row
		chan_at++;
		if (chan_at >= c) begin
			chan_at = 0;
			col_at++;
			win_col_at++;
			if (win_col_at >= pw)
				win_col_at = 0;
			if (col_at >= w) begin
				col_at = 0;
				win_col_at = 0;
				row_at++;
				win_row_at++;
				if (win_row_at >= ph)
					win_row_at = 0;
				if (row_at >= h) begin
					row_at = 0;
					win_row_at = 0;
				end
			end
		end
	endfunction

	// result checker and quiet-cycle counter, both on the rising edge
	always @(posedge clk) begin
		pooled_word_t want;
		if (arst_n) begin
			if ((sample_valid && sample_ready) || (pooled_valid && pooled_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (pooled_valid && pooled_ready) begin
				results_taken++;
				if (expected_pooled.size() == 0) begin
					error_count++;
					$display("%0t: pooled word with none expected, got pooled %h done %b",
						$time, pooled, tensor_done);
				end else begin
					want = expected_pooled.pop_front();
					if (pooled !== want.pooled) begin
						error_count++;
						$display("%0t: pooled expected %h actual %h", $time, want.pooled, pooled);
					end
					if (tensor_done !== want.done) begin
						error_count++;
						$display("%0t: tensor_done expected %b actual %b", $time, want.done,
							tensor_done);
					end
				end
			end
		end
	end

	// receiver: random wait before each pooled word while sink_idle is set, plus a long hold-off
	int unsigned results_noted = 0;
	int unsigned sink_gap = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;

	always @(negedge clk) begin
		if (results_taken != results_noted) begin
			results_noted = results_taken;
			sink_gap = sink_idle ? $urandom_range(0, 7) : 0;
		end
		if (hold_id != hold_seen) begin
			hold_seen = hold_id;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			pooled_ready <= 1'b0;
			hold_left--;
		end else if (sink_gap > 0) begin
			pooled_ready <= 1'b0;
			sink_gap--;
		end else begin
			pooled_ready <= 1'b1;
		end
	end

	// watchdog: the run ends if no word moves on either side for too long
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// sample word with a bias towards the extremes of the signed range
	function automatic logic [SAMPLE_BITS-1:0] random_word();
		case ($urandom_range(0, 9))
			0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			2: return '0;
			3: return '1;
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	// offer one sample word, hold it until taken, then feed the shadow model
	task automatic send_word(input logic [SAMPLE_BITS-1:0] word);
		int unsigned gap;
		gap = src_idle ? $urandom_range(0, 7) : 0;
		@(negedge clk);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample <= word;
		sample_valid <= 1'b1;
		do @(posedge clk); while (!sample_ready);
		pool_predict(word);
	endtask

	// stop offering and wait for every pooled word still owed
	task automatic drain();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (expected_pooled.size() != 0)
			@(posedge clk);
	endtask

	// drain, then give words that make no result time to leave the pipeline
	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		shadow_write(idx, data);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_shape(input logic [CFG_DATA_BITS-1:0] ph, input logic [CFG_DATA_BITS-1:0] pw,
			input logic [CFG_DATA_BITS-1:0] h, input logic [CFG_DATA_BITS-1:0] w,
			input logic [CFG_DATA_BITS-1:0] c);
		write_reg(REG_POOL_HEIGHT, ph);
		write_reg(REG_POOL_WIDTH, pw);
		write_reg(REG_IN_HEIGHT, h);
		write_reg(REG_IN_WIDTH, w);
		write_reg(REG_CHANNEL_COUNT, c);
	endtask

	// reset shape is a 2x2 window over a 1x1 tensor, so nothing ever comes out
	task automatic test_reset_shape();
		repeat (3) send_word(random_word());
		settle();
	endtask

	// 1x1 windows: each word comes straight back, signed extremes included
	task automatic test_sample_extremes();
		logic [SAMPLE_BITS-1:0] words [5];
		words = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h8000};
		set_shape(1, 1, 2, 2, 1);
		foreach (words[i])
			send_word(words[i]);
		settle();
	endtask

	// zero in every register acts as one, so every word closes a whole tensor
	task automatic test_zero_sizes();
		set_shape(0, 0, 0, 0, 0);
		send_word(16'h1234);
		send_word(16'hedcb);
		settle();
	endtask

	// 3x3 tensor under a 2x2 window: one result, right column and bottom row dropped
	task automatic test_trailing_edges();
		logic [SAMPLE_BITS-1:0] words [9];
		words = '{16'h0005, 16'h8000, 16'h7fff,
			16'h8001, 16'hffff, 16'h7fff,
			16'h7fff, 16'h7fff, 16'h7fff};
		sink_idle = 1'b0;
		set_shape(2, 2, 3, 3, 1);
		foreach (words[i])
			send_word(words[i]);
		settle();
		sink_idle = 1'b1;
	endtask

	// writes to the spare indexes change nothing but still drop the partial window
	task automatic test_spare_index_restart();
		set_shape(1, 2, 1, 2, 1);
		send_word(16'h7fff);
		settle();
		for (int i = REG_FIRST_SPARE; i <= INDEX_TOP; i++)
			write_reg(CFG_INDEX_BITS'(i), '1);
		send_word(16'h8000);
		send_word(16'h0001);
		settle();
	endtask

	// oversized values through the upper data bits, each counter walked to its end
	task automatic test_size_limits();
		// 16-row window over 1024 rows, plus a couple of words into the next tensor
		set_shape('1, 11'h7e1, '1, 1, 1);
		for (int i = 0; i < HEIGHT_LIMIT + 2; i++)
			send_word(random_word());
		settle();
		// full width in 16-column windows
		src_idle = 1'b0;
		set_shape(1, 16, 1, 11'h1ff, 0);
		for (int i = 0; i < MAX_WIDTH; i++)
			send_word(random_word());
		settle();
		// all 64 channels under a 2x1 window
		src_idle = 1'b1;
		set_shape(2, 1, 2, 1, '1);
		for (int i = 0; i < 2 * MAX_CHANNELS; i++)
			send_word(random_word());
		settle();
	endtask

	// receiver stalls for a long stretch while the sender keeps offering words
	task automatic test_back_pressure();
		src_idle = 1'b0;
		sink_idle = 1'b0;
		set_shape(1, 1, 4, 4, 1);
		hold_len = HOLD_CYCLES;
		hold_id++;
		for (int i = 0; i < 24; i++)
			send_word(random_word());
		settle();
		src_idle = 1'b1;
		sink_idle = 1'b1;
	endtask

	// random shapes, mostly small, whole tensors with a random tail, cut off at 160 words
	task automatic test_random_tensors();
		int unsigned sent, count, tensor_words;
		logic [CFG_DATA_BITS-1:0] ph, pw, h, w, c;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			src_idle = ($urandom_range(0, 3) != 0);
			sink_idle = ($urandom_range(0, 3) != 0);
			ph = CFG_DATA_BITS'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) :
				$urandom_range(1, 3));
			pw = CFG_DATA_BITS'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) :
				$urandom_range(1, 3));
			h = CFG_DATA_BITS'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 20) :
				$urandom_range(1, 8));
			w = CFG_DATA_BITS'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 20) :
				$urandom_range(1, 8));
			c = CFG_DATA_BITS'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) :
				$urandom_range(1, 3));
			// junk above the register width now and then
			if ($urandom_range(0, 3) == 0) begin
				ph[CFG_DATA_BITS-1:PH_BITS] = (CFG_DATA_BITS-PH_BITS)'($urandom());
				pw[CFG_DATA_BITS-1:PW_BITS] = (CFG_DATA_BITS-PW_BITS)'($urandom());
				w[CFG_DATA_BITS-1:W_BITS] = (CFG_DATA_BITS-W_BITS)'($urandom());
				c[CFG_DATA_BITS-1:C_BITS] = (CFG_DATA_BITS-C_BITS)'($urandom());
			end
			set_shape(ph, pw, h, w, c);
			if ($urandom_range(0, 5) == 0)
				write_reg(CFG_INDEX_BITS'($urandom_range(REG_FIRST_SPARE, INDEX_TOP)), '1);
			tensor_words = clipped(rows_reg, HEIGHT_LIMIT) * clipped(cols_reg, MAX_WIDTH) *
				clipped(chans_reg, MAX_CHANNELS);
			count = tensor_words * $urandom_range(1, 2);
			if ($urandom_range(0, 3) == 0)
				count += $urandom_range(0, tensor_words - 1);
			if (count > 160)
				count = 160;
			for (int i = 0; i < count; i++) begin
				send_word(random_word());
				// now and then the sender pauses until the block has caught up
				if ($urandom_range(0, 63) == 0)
					drain();
			end
			sent += count;
			settle();
		end
	endtask

	initial begin
		restart_tensor();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_shape();
		test_sample_extremes();
		test_zero_sizes();
		test_trailing_edges();
		test_spare_index_restart();
		test_back_pressure();
		test_size_limits();
		test_random_tensors();

		// tail: anything arriving now is an unexpected word
		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_pooled.size() != 0) begin
			error_count++;
			$display("%0t: %0d pooled words never arrived", $time, expected_pooled.size());
		end
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
